@@ hdl/pcfd_pkg.sv @@
`default_nettype none

package pcfd_pkg;

  localparam int unsigned DW         = 32;
  localparam int unsigned ALPHA_FRAC = 16;
  localparam int unsigned PC_W       = 5;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic signed [DW-1:0]   data_t;
  typedef logic signed [DW+1:0]   wide_t;
  typedef logic        [2*DW-1:0] prod_t;
  typedef logic        [DW-2:0]   limit_t;
  typedef logic        [ALPHA_FRAC:0] alpha_t;

  localparam data_t  DATA_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam data_t  DATA_MIN  = {1'b1, {(DW-1){1'b0}}};
  localparam alpha_t ALPHA_ONE = {1'b1, {ALPHA_FRAC{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_KP,
    CFG_KI,
    CFG_KD,
    CFG_OLIM,
    CFG_ILIM,
    CFG_ALPHA
  } cfg_idx_e;

  typedef struct packed {
    logic   mode;
    data_t  kp;
    data_t  ki;
    data_t  kd;
    limit_t olim;
    limit_t ilim;
    alpha_t alpha;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_HALVE,
    OP_MUL,
    OP_RND,
    OP_ACCLD,
    OP_ACCADD,
    OP_CLAMP,
    OP_DONE
  } op_e;

  typedef enum logic [4:0] {
    SRC_S,
    SRC_F,
    SRC_LSP,
    SRC_LF,
    SRC_LE,
    SRC_LFD,
    SRC_INT,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_FLT,
    SRC_ERR,
    SRC_KP,
    SRC_KI,
    SRC_KD,
    SRC_ALPHA,
    SRC_NALPHA,
    SRC_OLIM,
    SRC_ILIM
  } src_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_INT,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_FLT,
    DST_ERR,
    DST_Y
  } dst_e;

  typedef enum logic [1:0] {
    SH_ALPHA,
    SH_FRAC,
    SH_FRAC1
  } shift_e;

  typedef enum logic [1:0] {
    CND_NONE,
    CND_EQ,
    CND_POS
  } cond_e;

  typedef struct packed {
    op_e             op;
    src_e            src_a;
    src_e            src_b;
    dst_e            dst;
    shift_e          sh;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic   load;
    logic   exec;
    logic   commit;
    uword_t uw;
  } ctl_t;

  function automatic data_t sat_w(input wide_t v);
    data_t r;
    if (v > wide_t'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (v < wide_t'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = data_t'(v);
    end
    return r;
  endfunction

  function automatic data_t clamp_sym(input data_t v, input data_t lim);
    data_t r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic uword_t uw(input op_e op, input src_e a, input src_e b, input dst_e d,
                                input shift_e sh, input cond_e c, input int unsigned tgt);
    uword_t w;
    w.op     = op;
    w.src_a  = a;
    w.src_b  = b;
    w.dst    = d;
    w.sh     = sh;
    w.cond   = c;
    w.target = PC_W'(tgt);
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pcfd_ucode.sv @@
`default_nettype none

module pcfd_ucode import pcfd_pkg::*; (
  input  wire logic [PC_W-1:0] pc_i,
  output uword_t               uword_o
);

  always_comb begin
    case (pc_i)
      // skip the integral halving when the setpoint is unchanged
      5'd0:  uword_o = uw(OP_NOP,    SRC_S,   SRC_LSP,    DST_NONE, SH_FRAC,  CND_EQ,   2);
      5'd1:  uword_o = uw(OP_HALVE,  SRC_INT, SRC_INT,    DST_INT,  SH_FRAC,  CND_NONE, 0);
      5'd2:  uword_o = uw(OP_SUB,    SRC_LF,  SRC_F,      DST_T0,   SH_FRAC,  CND_NONE, 0);
      5'd3:  uword_o = uw(OP_MUL,    SRC_T0,  SRC_ALPHA,  DST_NONE, SH_FRAC,  CND_NONE, 0);
      5'd4:  uword_o = uw(OP_RND,    SRC_T0,  SRC_T0,     DST_T1,   SH_ALPHA, CND_NONE, 0);
      5'd5:  uword_o = uw(OP_MUL,    SRC_LFD, SRC_NALPHA, DST_NONE, SH_FRAC,  CND_NONE, 0);
      5'd6:  uword_o = uw(OP_RND,    SRC_T0,  SRC_T0,     DST_T2,   SH_ALPHA, CND_NONE, 0);
      5'd7:  uword_o = uw(OP_ADD,    SRC_T1,  SRC_T2,     DST_FLT,  SH_FRAC,  CND_NONE, 0);
      5'd8:  uword_o = uw(OP_SUB,    SRC_S,   SRC_F,      DST_ERR,  SH_FRAC,  CND_NONE, 0);
      // position form uses the error itself, delta form its difference
      5'd9:  uword_o = uw(OP_MOV,    SRC_ERR, SRC_ERR,    DST_T0,   SH_FRAC,  CND_POS,  11);
      5'd10: uword_o = uw(OP_SUB,    SRC_ERR, SRC_LE,     DST_T0,   SH_FRAC,  CND_NONE, 0);
      5'd11: uword_o = uw(OP_MUL,    SRC_T0,  SRC_KP,     DST_NONE, SH_FRAC,  CND_NONE, 0);
      5'd12: uword_o = uw(OP_RND,    SRC_T0,  SRC_T0,     DST_T1,   SH_FRAC,  CND_NONE, 0);
      5'd13: uword_o = uw(OP_ADD,    SRC_ERR, SRC_LE,     DST_T0,   SH_FRAC,  CND_NONE, 0);
      5'd14: uword_o = uw(OP_MUL,    SRC_T0,  SRC_KI,     DST_NONE, SH_FRAC,  CND_NONE, 0);
      5'd15: uword_o = uw(OP_RND,    SRC_T0,  SRC_T0,     DST_T2,   SH_FRAC1, CND_NONE, 0);
      5'd16: uword_o = uw(OP_ACCLD,  SRC_INT, SRC_T2,     DST_NONE, SH_FRAC,  CND_NONE, 0);
      5'd17: uword_o = uw(OP_CLAMP,  SRC_T0,  SRC_ILIM,   DST_INT,  SH_FRAC,  CND_NONE, 0);
      5'd18: uword_o = uw(OP_MUL,    SRC_FLT, SRC_KD,     DST_NONE, SH_FRAC,  CND_NONE, 0);
      5'd19: uword_o = uw(OP_RND,    SRC_T0,  SRC_T0,     DST_T2,   SH_FRAC,  CND_NONE, 0);
      5'd20: uword_o = uw(OP_ACCLD,  SRC_T1,  SRC_INT,    DST_NONE, SH_FRAC,  CND_NONE, 0);
      5'd21: uword_o = uw(OP_ACCADD, SRC_T2,  SRC_T2,     DST_NONE, SH_FRAC,  CND_NONE, 0);
      5'd22: uword_o = uw(OP_CLAMP,  SRC_T0,  SRC_OLIM,   DST_Y,    SH_FRAC,  CND_NONE, 0);
      default: uword_o = uw(OP_DONE, SRC_T0,  SRC_T0,     DST_NONE, SH_FRAC,  CND_NONE, 0);
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/pcfd_seq.sv @@
`default_nettype none

module pcfd_seq import pcfd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            out_free_i,
  input  wire logic            eq_i,
  input  wire logic            mode_i,
  input  wire uword_t          uword_i,
  output logic [PC_W-1:0]      pc_o,
  output ctl_t                 ctl_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic            is_done;
  logic            take_jump;

  assign is_done    = (uword_i.op == OP_DONE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign pc_o       = pc_q;

  always_comb begin
    case (uword_i.cond)
      CND_EQ:  take_jump = eq_i;
      CND_POS: take_jump = ~mode_i;
      default: take_jump = 1'b0;
    endcase
  end

  always_comb begin
    ctl_o.load   = in_valid_i && (state_q == ST_IDLE);
    ctl_o.exec   = (state_q == ST_RUN) && !is_done;
    ctl_o.commit = (state_q == ST_RUN) && is_done && out_free_i;
    ctl_o.uw     = uword_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            pc_q    <= '0;
          end
        end
        ST_RUN: begin
          if (is_done) begin
            // hold on the last step until the output register is free
            if (out_free_i) begin
              state_q <= ST_IDLE;
            end
          end else if (take_jump) begin
            pc_q <= uword_i.target;
          end else begin
            pc_q <= pc_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/pcfd_datapath.sv @@
`default_nettype none

module pcfd_datapath import pcfd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctl_t  ctl_i,
  input  wire cfg_t  cfg_i,
  input  wire data_t setpoint_i,
  input  wire data_t feedback_i,
  output logic       eq_o,
  output data_t      y_o
);

  localparam prod_t HALF_A  = prod_t'(1) << (ALPHA_FRAC - 1);
  localparam prod_t HALF_F  = prod_t'(1) << (FRAC_BITS - 1);
  localparam prod_t HALF_F1 = prod_t'(1) << FRAC_BITS;
  localparam prod_t MAG_MAX = prod_t'(DATA_MAX);

  data_t s_q, f_q, lsp_q, lf_q, le_q, lfd_q, int_q;
  data_t t0_q, t1_q, t2_q, flt_q, err_q, y_q;
  wide_t acc_q;
  prod_t prod_q;
  logic  neg_q;

  data_t a_op, b_op;
  wide_t a_w, b_w;
  logic [DW-1:0] a_mag, b_mag;
  prod_t m;
  data_t rnd;
  data_t res;
  logic  wr;
  uword_t w;

  assign w = ctl_i.uw;

  always_comb begin
    case (w.src_a)
      SRC_S:      a_op = s_q;
      SRC_F:      a_op = f_q;
      SRC_LSP:    a_op = lsp_q;
      SRC_LF:     a_op = lf_q;
      SRC_LE:     a_op = le_q;
      SRC_LFD:    a_op = lfd_q;
      SRC_INT:    a_op = int_q;
      SRC_T0:     a_op = t0_q;
      SRC_T1:     a_op = t1_q;
      SRC_T2:     a_op = t2_q;
      SRC_FLT:    a_op = flt_q;
      SRC_ERR:    a_op = err_q;
      default:    a_op = t0_q;
    endcase
  end

  always_comb begin
    case (w.src_b)
      SRC_F:      b_op = f_q;
      SRC_LSP:    b_op = lsp_q;
      SRC_LE:     b_op = le_q;
      SRC_INT:    b_op = int_q;
      SRC_T2:     b_op = t2_q;
      SRC_KP:     b_op = cfg_i.kp;
      SRC_KI:     b_op = cfg_i.ki;
      SRC_KD:     b_op = cfg_i.kd;
      SRC_ALPHA:  b_op = data_t'(cfg_i.alpha);
      SRC_NALPHA: b_op = data_t'(ALPHA_ONE - cfg_i.alpha);
      SRC_OLIM:   b_op = data_t'(cfg_i.olim);
      SRC_ILIM:   b_op = data_t'(cfg_i.ilim);
      default:    b_op = t0_q;
    endcase
  end

  assign a_w   = wide_t'(a_op);
  assign b_w   = wide_t'(b_op);
  assign a_mag = a_op[DW-1] ? (~a_op + 1'b1) : a_op;
  assign b_mag = b_op[DW-1] ? (~b_op + 1'b1) : b_op;
  assign eq_o  = (a_op == b_op);
  assign y_o   = y_q;

  // round half away from zero on the magnitude, then restore sign and saturate
  always_comb begin
    case (w.sh)
      SH_ALPHA: m = (prod_q + HALF_A) >> ALPHA_FRAC;
      SH_FRAC1: m = (prod_q + HALF_F1) >> (FRAC_BITS + 1);
      default:  m = (prod_q + HALF_F) >> FRAC_BITS;
    endcase
    if (neg_q) begin
      rnd = (m > MAG_MAX + 1'b1) ? DATA_MIN : data_t'(~m + 1'b1);
    end else begin
      rnd = (m > MAG_MAX) ? DATA_MAX : data_t'(m);
    end
  end

  always_comb begin
    res = a_op;
    wr  = 1'b0;
    case (w.op)
      OP_MOV: begin
        res = a_op;
        wr  = 1'b1;
      end
      OP_ADD: begin
        res = sat_w(a_w + b_w);
        wr  = 1'b1;
      end
      OP_SUB: begin
        res = sat_w(a_w - b_w);
        wr  = 1'b1;
      end
      OP_HALVE: begin
        // truncate toward zero
        res = (a_op >>> 1) + data_t'(a_op[DW-1] & a_op[0]);
        wr  = 1'b1;
      end
      OP_RND: begin
        res = rnd;
        wr  = 1'b1;
      end
      OP_CLAMP: begin
        res = clamp_sym(sat_w(acc_q), b_op);
        wr  = 1'b1;
      end
      default: begin
        res = a_op;
        wr  = 1'b0;
      end
    endcase
    wr = wr && ctl_i.exec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsp_q <= '0;
      lf_q  <= '0;
      le_q  <= '0;
      lfd_q <= '0;
      int_q <= '0;
    end else begin
      if (wr && (w.dst == DST_INT)) begin
        int_q <= res;
      end
      if (ctl_i.commit) begin
        lsp_q <= s_q;
        lf_q  <= f_q;
        le_q  <= err_q;
        lfd_q <= flt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      s_q <= setpoint_i;
      f_q <= feedback_i;
    end
    if (wr) begin
      case (w.dst)
        DST_T0:  t0_q  <= res;
        DST_T1:  t1_q  <= res;
        DST_T2:  t2_q  <= res;
        DST_FLT: flt_q <= res;
        DST_ERR: err_q <= res;
        DST_Y:   y_q   <= res;
        default: ;
      endcase
    end
    if (ctl_i.exec) begin
      case (w.op)
        OP_MUL: begin
          prod_q <= a_mag * b_mag;
          neg_q  <= a_op[DW-1] ^ b_op[DW-1];
        end
        OP_ACCLD:  acc_q <= a_w + b_w;
        OP_ACCADD: acc_q <= acc_q + a_w;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/pid_controller_filtered_derivative.sv @@
// The integral halving step runs only on a setpoint change, the error difference only in delta
// form. A new input is taken only once the previous result has been committed to drive_o;
// up to 23 microcode steps and a done step run on one shared adder/clamp unit and one 32x32
// multiplier, and the done step holds while the output waits.
// Reset: configuration returns to its defaults, all controller state (previous setpoint,
// feedback, error, filtered derivative, integral) clears to zero, no item in flight.
`default_nettype none

module pid_controller_filtered_derivative import pcfd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DW-1:0]        cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [DW-1:0] setpoint_i,
  input  wire logic signed [DW-1:0] feedback_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [DW-1:0]      drive_o
);

  cfg_t            cfg_q;
  logic [PC_W-1:0] pc;
  uword_t          uword;
  ctl_t            ctl;
  logic            eq;
  data_t           y;
  logic            out_valid_q;
  data_t           drive_q;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= 1'b0;
      cfg_q.kp    <= '0;
      cfg_q.ki    <= '0;
      cfg_q.kd    <= '0;
      cfg_q.olim  <= '1;
      cfg_q.ilim  <= '1;
      cfg_q.alpha <= ALPHA_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: cfg_q.mode <= cfg_wdata_i[0];
        CFG_KP:   cfg_q.kp   <= data_t'(cfg_wdata_i);
        CFG_KI:   cfg_q.ki   <= data_t'(cfg_wdata_i);
        CFG_KD:   cfg_q.kd   <= data_t'(cfg_wdata_i);
        CFG_OLIM: cfg_q.olim <= cfg_wdata_i[DW-2:0];
        CFG_ILIM: cfg_q.ilim <= cfg_wdata_i[DW-2:0];
        CFG_ALPHA: begin
          // weights above one act as one
          if (cfg_wdata_i[ALPHA_FRAC:0] > ALPHA_ONE) begin
            cfg_q.alpha <= ALPHA_ONE;
          end else begin
            cfg_q.alpha <= cfg_wdata_i[ALPHA_FRAC:0];
          end
        end
        default: ;
      endcase
    end
  end

  pcfd_ucode u_ucode (
    .pc_i    (pc),
    .uword_o (uword)
  );

  pcfd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .eq_i       (eq),
    .mode_i     (cfg_q.mode),
    .uword_i    (uword),
    .pc_o       (pc),
    .ctl_o      (ctl)
  );

  pcfd_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cfg_i      (cfg_q),
    .setpoint_i (setpoint_i),
    .feedback_i (feedback_i),
    .eq_o       (eq),
    .y_o        (y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.commit) begin
      drive_q <= y;
    end
  end

endmodule

`default_nettype wire
